/* hdl/dpd_pkg.sv */
package dpd_pkg;

    localparam int CodeW = 12;
    localparam int ChanW = 3;
    localparam int WarmW = 10;
    localparam logic [WarmW-1:0] WARMUP_STEPS = 10'd1000;

    // datapath widths
    localparam int MulW  = 24;
    localparam int ProdW = 2 * MulW;
    localparam int DW    = 22;
    localparam int XW    = 18;
    localparam int X2W   = 19;
    localparam int X3W   = 20;
    localparam int X5W   = 22;
    localparam int Q3W   = 17;
    localparam int Q5W   = 15;

    // q16 voltage constants
    localparam int Q16_SH   = 16;
    localparam int Q16_ONE  = 65536;
    localparam int V_OFFSET = 98304;
    localparam int S_SAT    = 216269;

    // reciprocal multipliers and their shifts
    localparam logic signed [MulW-1:0] K_DIV5   = MulW'(52429);
    localparam logic signed [MulW-1:0] K_DIV6   = MulW'(349526);
    localparam logic signed [MulW-1:0] K_DIV120 = MulW'(2236963);
    localparam logic signed [MulW-1:0] K_DIV33  = MulW'(254201);
    localparam logic signed [MulW-1:0] K_DAMP   = MulW'(6554);
    localparam int SH5   = 18;
    localparam int SH6   = 21;
    localparam int SH120 = 28;
    localparam int SH33  = 23;

    localparam logic [CodeW-1:0] CODE_MAX = 12'hFFF;

    localparam logic [ChanW-1:0] WORD_LAST = 3'd6;

    typedef logic [3:0] t_mul_sel;
    localparam t_mul_sel MUL_IDLE = 4'd0;
    localparam t_mul_sel MUL_POS  = 4'd1;
    localparam t_mul_sel MUL_VEL  = 4'd2;
    localparam t_mul_sel MUL_X0SQ = 4'd3;
    localparam t_mul_sel MUL_DAMP = 4'd4;
    localparam t_mul_sel MUL_X2X0 = 4'd5;
    localparam t_mul_sel MUL_X3X2 = 4'd6;
    localparam t_mul_sel MUL_Q3   = 4'd7;
    localparam t_mul_sel MUL_Q5   = 4'd8;
    localparam t_mul_sel MUL_CONV = 4'd9;

    typedef struct packed {
        t_mul_sel         mul_sel;
        logic             ld_in;
        logic             ld_x0;
        logic             ld_x1;
        logic             ld_x2;
        logic             ld_damp;
        logic             ld_x3;
        logic             ld_x5;
        logic             ld_q3;
        logic             ld_q5;
        logic             ld_s0;
        logic             ld_s1;
        logic             ld_c0;
        logic             ld_c1;
        logic             ld_out;
        logic [ChanW-1:0] word;
    } t_dp_cmd;

    function automatic logic [ChanW-1:0] chan_of(input logic [ChanW-1:0] k);
        logic [ChanW-1:0] c;
        case (k)
            3'd0:    c = 3'd0;
            3'd1:    c = 3'd1;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd3;
            3'd4:    c = 3'd5;
            3'd5:    c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    // q16 product scaling, truncated toward zero
    function automatic logic signed [ProdW-1:0] q16_trunc(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-1:0] bias;
        bias = p[ProdW-1] ? ProdW'(Q16_ONE - 1) : '0;
        return (p + bias) >>> Q16_SH;
    endfunction

endpackage

/* hdl/dpd_ctrl.sv */
module dpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dpd_pkg::t_dp_cmd  o_cmd
);
    import dpd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_X0A  = 4'd1;
    localparam logic [3:0] S_X0B  = 4'd2;
    localparam logic [3:0] S_X1   = 4'd3;
    localparam logic [3:0] S_X2   = 4'd4;
    localparam logic [3:0] S_DMP  = 4'd5;
    localparam logic [3:0] S_X3   = 4'd6;
    localparam logic [3:0] S_X5A  = 4'd7;
    localparam logic [3:0] S_X5B  = 4'd8;
    localparam logic [3:0] S_Q3   = 4'd9;
    localparam logic [3:0] S_Q5   = 4'd10;
    localparam logic [3:0] S_S1   = 4'd11;
    localparam logic [3:0] S_C1A  = 4'd12;
    localparam logic [3:0] S_C1B  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]       r_state, n_state;
    logic             r_busy, n_busy;
    logic [ChanW-1:0] r_word, n_word;
    logic             out_xfer;
    logic             out_free;

    assign out_xfer    = r_busy && i_out_ready;
    assign out_free    = !r_busy || (out_xfer && (r_word == WORD_LAST));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.mul_sel = MUL_IDLE;
        o_cmd.word = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = S_X0A;
                end
            end
            S_X0A: begin
                o_cmd.mul_sel = MUL_POS;
                n_state = S_X0B;
            end
            S_X0B: begin
                o_cmd.ld_x0 = 1'b1;
                o_cmd.mul_sel = MUL_VEL;
                n_state = S_X1;
            end
            S_X1: begin
                o_cmd.ld_x1 = 1'b1;
                o_cmd.mul_sel = MUL_X0SQ;
                n_state = S_X2;
            end
            S_X2: begin
                o_cmd.ld_x2 = 1'b1;
                o_cmd.ld_s0 = 1'b1;
                o_cmd.mul_sel = MUL_DAMP;
                n_state = S_DMP;
            end
            S_DMP: begin
                o_cmd.ld_damp = 1'b1;
                o_cmd.mul_sel = MUL_X2X0;
                n_state = S_X3;
            end
            S_X3: begin
                o_cmd.ld_x3 = 1'b1;
                o_cmd.mul_sel = MUL_CONV;
                n_state = S_X5A;
            end
            S_X5A: begin
                o_cmd.ld_c0 = 1'b1;
                o_cmd.mul_sel = MUL_X3X2;
                n_state = S_X5B;
            end
            S_X5B: begin
                o_cmd.ld_x5 = 1'b1;
                o_cmd.mul_sel = MUL_Q3;
                n_state = S_Q3;
            end
            S_Q3: begin
                o_cmd.ld_q3 = 1'b1;
                o_cmd.mul_sel = MUL_Q5;
                n_state = S_Q5;
            end
            S_Q5: begin
                o_cmd.ld_q5 = 1'b1;
                n_state = S_S1;
            end
            S_S1: begin
                o_cmd.ld_s1 = 1'b1;
                n_state = S_C1A;
            end
            S_C1A: begin
                o_cmd.mul_sel = MUL_CONV;
                n_state = S_C1B;
            end
            S_C1B: begin
                o_cmd.ld_c1 = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_word = r_word;
        if (out_xfer) begin
            if (r_word == WORD_LAST) begin
                n_busy = 1'b0;
                n_word = '0;
            end else begin
                n_word = r_word + 3'd1;
            end
        end
        if (o_cmd.ld_out) begin
            n_busy = 1'b1;
            n_word = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_word  <= n_word;
        end
    end

endmodule

/* hdl/dpd_datapath.sv */
module dpd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpd_pkg::t_dp_cmd            i_cmd,
    input  logic [dpd_pkg::CodeW-1:0]   i_position_code,
    input  logic [dpd_pkg::CodeW-1:0]   i_velocity_code,
    input  logic [dpd_pkg::CodeW-1:0]   i_forcing_code,
    output logic [dpd_pkg::ChanW-1:0]   o_dac_channel,
    output logic [dpd_pkg::CodeW-1:0]   o_dac_code,
    output logic                        o_last_word
);
    import dpd_pkg::*;

    logic [WarmW-1:0]        r_warmup_count;
    logic                    r_warm;
    logic [CodeW-1:0]        r_pos, r_vel, r_ff;
    logic signed [ProdW-1:0] r_prod;
    logic signed [XW-1:0]    r_x0, r_x1, r_damp;
    logic signed [X2W-1:0]   r_x2;
    logic signed [X3W-1:0]   r_x3;
    logic signed [X5W-1:0]   r_x5;
    logic signed [Q3W-1:0]   r_q3;
    logic signed [Q5W-1:0]   r_q5;
    logic signed [DW-1:0]    r_s;
    logic [CodeW-1:0]        r_c0, r_c1;
    logic [CodeW-1:0]        r_o_c0, r_o_c1, r_o_ff;

    logic signed [MulW-1:0]  mul_a, mul_b;
    logic signed [ProdW-1:0] mul_p;
    logic signed [ProdW-1:0] prod_q16;
    logic signed [MulW-1:0]  x3_abs, x5_abs, conv_m;
    logic [CodeW-1:0]        code_sel;
    logic signed [DW-1:0]    x_conv;
    logic signed [DW-1:0]    d0, d1;
    logic signed [Q3W-1:0]   q3_mag;
    logic signed [Q5W-1:0]   q5_mag;
    logic [CodeW-1:0]        c_conv;

    assign x3_abs = r_x3[X3W-1] ? -MulW'(r_x3) : MulW'(r_x3);
    assign x5_abs = r_x5[X5W-1] ? -MulW'(r_x5) : MulW'(r_x5);
    // 5*s/8, first half of the scaling by 5/264
    assign conv_m = ((MulW'(r_s) <<< 2) + MulW'(r_s)) >>> 3;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_POS: begin
                mul_a = MulW'({r_pos, 2'b00});
                mul_b = K_DIV5;
            end
            MUL_VEL: begin
                mul_a = MulW'({r_vel, 2'b00});
                mul_b = K_DIV5;
            end
            MUL_X0SQ: begin
                mul_a = MulW'(r_x0);
                mul_b = MulW'(r_x0);
            end
            MUL_DAMP: begin
                mul_a = K_DAMP;
                mul_b = MulW'(r_x1);
            end
            MUL_X2X0: begin
                mul_a = MulW'(r_x2);
                mul_b = MulW'(r_x0);
            end
            MUL_X3X2: begin
                mul_a = MulW'(r_x3);
                mul_b = MulW'(r_x2);
            end
            MUL_Q3: begin
                mul_a = x3_abs;
                mul_b = K_DIV6;
            end
            MUL_Q5: begin
                mul_a = x5_abs;
                mul_b = K_DIV120;
            end
            MUL_CONV: begin
                mul_a = conv_m;
                mul_b = K_DIV33;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = ProdW'(mul_a) * ProdW'(mul_b);
    assign prod_q16 = q16_trunc(r_prod);

    // code to voltage: 52*code + floor(4*code/5) - 1.5
    assign code_sel = i_cmd.ld_x0 ? r_pos : r_vel;
    assign x_conv   = DW'({code_sel, 5'b00000}) + DW'({code_sel, 4'b0000})
                    + DW'({code_sel, 2'b00}) + DW'(r_prod[SH5 +: CodeW])
                    - DW'(V_OFFSET);

    assign q3_mag = {1'b0, r_prod[SH6 +: Q3W-1]};
    assign q5_mag = {1'b0, r_prod[SH120 +: Q5W-1]};

    assign d0 = r_warm ? (DW'(Q16_ONE) - DW'(r_x0)) : DW'(r_x1);
    assign d1 = r_warm ? -DW'(r_x1)
                       : (-DW'(r_x0) + DW'(r_q3) - DW'(r_q5) - DW'(r_damp));

    always_comb begin
        if (r_s[DW-1] || (r_s == '0)) begin
            c_conv = '0;
        end else if (r_s >= DW'(S_SAT)) begin
            c_conv = CODE_MAX;
        end else begin
            c_conv = r_prod[SH33 +: CodeW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_count <= '0;
        end else if (i_cmd.ld_in && (r_warmup_count < WARMUP_STEPS)) begin
            r_warmup_count <= r_warmup_count + 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.ld_in) begin
            r_pos  <= i_position_code;
            r_vel  <= i_velocity_code;
            r_ff   <= i_forcing_code;
            r_warm <= (r_warmup_count < WARMUP_STEPS);
        end
        if (i_cmd.ld_x0) begin
            r_x0 <= XW'(x_conv);
        end
        if (i_cmd.ld_x1) begin
            r_x1 <= XW'(x_conv);
        end
        if (i_cmd.ld_x2) begin
            r_x2 <= X2W'(prod_q16);
        end
        if (i_cmd.ld_damp) begin
            r_damp <= XW'(prod_q16);
        end
        if (i_cmd.ld_x3) begin
            r_x3 <= X3W'(prod_q16);
        end
        if (i_cmd.ld_x5) begin
            r_x5 <= X5W'(prod_q16);
        end
        if (i_cmd.ld_q3) begin
            r_q3 <= r_x3[X3W-1] ? -q3_mag : q3_mag;
        end
        if (i_cmd.ld_q5) begin
            r_q5 <= r_x5[X5W-1] ? -q5_mag : q5_mag;
        end
        if (i_cmd.ld_s0) begin
            r_s <= d0 + DW'(V_OFFSET);
        end else if (i_cmd.ld_s1) begin
            r_s <= d1 + DW'(V_OFFSET);
        end
        if (i_cmd.ld_c0) begin
            r_c0 <= c_conv;
        end
        if (i_cmd.ld_c1) begin
            r_c1 <= c_conv;
        end
        if (i_cmd.ld_out) begin
            r_o_c0 <= r_c0;
            r_o_c1 <= r_c1;
            r_o_ff <= r_ff;
        end
    end

    always_comb begin
        case (i_cmd.word)
            3'd0:    o_dac_code = r_o_c0;
            3'd1:    o_dac_code = r_o_c1;
            default: o_dac_code = r_o_ff;
        endcase
    end

    assign o_dac_channel = chan_of(i_cmd.word);
    assign o_last_word   = (i_cmd.word == WORD_LAST);

endmodule

/* hdl/damped_pendulum_derivative_dac.sv */
// channel   direction  handshake                  payload
// sample    in         i_in_valid / o_in_ready    i_position_code, i_velocity_code,
//                                                 i_forcing_code
// dac word  out        o_out_valid / i_out_ready  o_dac_channel, o_dac_code, o_last_word
//
// a sample goes from transfer to a filled output buffer through a run of controller
// states, its products taken one at a time through the single shared 24x24 multiplier
// seven dac words then leave at one a cycle while i_out_ready is held high, as the
// next sample is worked on, so a new sample can be taken before the last one's words are out
// a stalled output holds the next sample in its final step until the buffer frees
// reset is synchronous, active low, and restarts the 1000-sample warm-up count
module damped_pendulum_derivative_dac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dpd_pkg::CodeW-1:0]   i_position_code,
    input  logic [dpd_pkg::CodeW-1:0]   i_velocity_code,
    input  logic [dpd_pkg::CodeW-1:0]   i_forcing_code,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dpd_pkg::ChanW-1:0]   o_dac_channel,
    output logic [dpd_pkg::CodeW-1:0]   o_dac_code,
    output logic                        o_last_word
);
    import dpd_pkg::*;

    t_dp_cmd cmd;

    dpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dpd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_position_code (i_position_code),
        .i_velocity_code (i_velocity_code),
        .i_forcing_code  (i_forcing_code),
        .o_dac_channel   (o_dac_channel),
        .o_dac_code      (o_dac_code),
        .o_last_word     (o_last_word)
    );

    // the final word always goes to channel 7, and channel 4 is never used
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_word) |-> (o_dac_channel == 3'd7))
        else $error("last word not on channel 7");

    a_no_chan4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dac_channel != 3'd4))
        else $error("word on unused channel");

    // a run of seven words is not broken after a transfer
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_word) |=> o_out_valid)
        else $error("word run broken");

    // a new sample cannot be taken in the cycle after one is
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sample taken while busy");

endmodule
